// ===== src/blag_pkg.sv =====
// Shared types and constants for the luma ASCII glyph block.
package blag_pkg;

	// Field widths
	localparam int COLOR_W   = 8;
	localparam int PSUM_W    = COLOR_W + 1;
	localparam int TOTAL_W   = COLOR_W + 2;
	localparam int GLYPH_W   = 7;
	localparam int BCOL_W    = 11;
	localparam int ROW_W_W   = 13;
	localparam int LUMA_W    = 18;
	localparam int LUMA_SHIFT = 15;
	localparam int RAMP_N    = 8;
	localparam int RAMP_IDX_W = 3;

	localparam int ROW_W_RESET = 640;

	// Luma weights in units of 1/256 (.27 / .67 / .06)
	localparam logic [7:0] WEIGHT_R = 8'd69;
	localparam logic [7:0] WEIGHT_G = 8'd172;
	localparam logic [7:0] WEIGHT_B = 8'd15;

	// Brightness ramp: ' ' '.' ':' 'o' 'O' '8' '#' '@'
	localparam logic [GLYPH_W-1:0] RAMP [RAMP_N] = '{
		7'd32, 7'd46, 7'd58, 7'd111, 7'd79, 7'd56, 7'd35, 7'd64
	};

	// Three pair sums of one horizontal pixel pair
	typedef struct packed {
		logic [PSUM_W-1:0] r;
		logic [PSUM_W-1:0] g;
		logic [PSUM_W-1:0] b;
	} pair_sum_t;

	// Stage 1 contents handed from the line buffer to the glyph stage
	typedef struct packed {
		logic              valid;
		pair_sum_t         sums;
		logic [BCOL_W-1:0] bcol;
		logic              done;
	} blag_s1_t;

	// One finished result
	typedef struct packed {
		logic [BCOL_W-1:0]  bcol;
		logic [COLOR_W-1:0] b_avg;
		logic [COLOR_W-1:0] g_avg;
		logic [COLOR_W-1:0] r_avg;
		logic [GLYPH_W-1:0] glyph;
		logic               done;
	} blag_result_t;

endpackage

// ===== src/blag_line.sv =====
// Column tracking, pair summing and the pair-sum line buffer.
module blag_line #(
	parameter int MAX_WIDTH = 4096,
	parameter int WW = 13
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      acc,
	input  logic [blag_pkg::COLOR_W-1:0] red,
	input  logic [blag_pkg::COLOR_W-1:0] green,
	input  logic [blag_pkg::COLOR_W-1:0] blue,
	input  logic                      frame_start,
	input  logic [WW-1:0]             eff_w,
	output blag_pkg::blag_s1_t        s1,
	output blag_pkg::pair_sum_t       line_rd
);
	import blag_pkg::*;

	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int AW = $clog2(LINE_DEPTH);

	logic [CW-1:0]        pixel_column_q;
	logic                 odd_row_q;
	logic [3*COLOR_W-1:0] first_of_pair_q;

	logic [CW-1:0] col_base;
	logic          odd_base;
	logic [CW-1:0] col;
	logic          odd;
	logic [WW-1:0] col_nxt;
	logic [WW-1:0] last_col;
	logic [AW-1:0] idx;
	pair_sum_t     sums;

	pair_sum_t line_mem [LINE_DEPTH];
	pair_sum_t rd_q;

	logic          valid_s1;
	pair_sum_t     sums_s1;
	logic [BCOL_W-1:0] bcol_s1;
	logic          done_s1;

	// Resolve column and row parity for the incoming pixel
	always_comb begin
		col_base = frame_start ? '0 : pixel_column_q;
		odd_base = frame_start ? 1'b0 : odd_row_q;
		if (WW'(col_base) >= eff_w) begin
			col = '0;
			odd = ~odd_base;
		end else begin
			col = col_base;
			odd = odd_base;
		end
		col_nxt  = WW'(col) + WW'(1);
		last_col = {eff_w[WW-1:1], 1'b0} - WW'(1);
		idx      = col[AW:1];
		sums.r   = PSUM_W'(first_of_pair_q[3*COLOR_W-1:2*COLOR_W]) + PSUM_W'(red);
		sums.g   = PSUM_W'(first_of_pair_q[2*COLOR_W-1:COLOR_W]) + PSUM_W'(green);
		sums.b   = PSUM_W'(first_of_pair_q[COLOR_W-1:0]) + PSUM_W'(blue);
	end

	// Advance column, row parity and the held first pixel of a pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_column_q  <= '0;
			odd_row_q       <= 1'b0;
			first_of_pair_q <= '0;
		end else if (acc) begin
			if (!col[0]) begin
				first_of_pair_q <= {red, green, blue};
			end
			if (col_nxt >= eff_w) begin
				pixel_column_q <= '0;
				odd_row_q      <= ~odd;
			end else begin
				pixel_column_q <= col_nxt[CW-1:0];
				odd_row_q      <= odd;
			end
		end
	end

	// Write pair sums on even rows, read them back on odd rows
	always_ff @(posedge clk) begin
		if (acc && col[0] && !odd) begin
			line_mem[idx] <= sums;
		end
		if (acc && col[0] && odd) begin
			rd_q <= line_mem[idx];
		end
	end

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= acc && col[0] && odd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sums_s1 <= sums;
			bcol_s1 <= BCOL_W'(col[CW-1:1]);
			done_s1 <= (WW'(col) == last_col);
		end
	end

	assign s1.valid = valid_s1;
	assign s1.sums  = sums_s1;
	assign s1.bcol  = bcol_s1;
	assign s1.done  = done_s1;
	assign line_rd  = rd_q;

endmodule

// ===== src/blag_glyph.sv =====
// Block totals, luma weighting, glyph lookup and the output register.
module blag_glyph (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  blag_pkg::blag_s1_t     s1,
	input  blag_pkg::pair_sum_t    line_rd,
	output logic                   res_valid,
	output blag_pkg::blag_result_t res
);
	import blag_pkg::*;

	logic [TOTAL_W-1:0] rt;
	logic [TOTAL_W-1:0] gt;
	logic [TOTAL_W-1:0] bt;
	logic [LUMA_W-1:0]  luma;

	logic               valid_s2;
	logic [TOTAL_W-1:0] rt_s2;
	logic [TOTAL_W-1:0] gt_s2;
	logic [TOTAL_W-1:0] bt_s2;
	logic [LUMA_W-1:0]  luma_s2;
	logic [BCOL_W-1:0]  bcol_s2;
	logic               done_s2;

	logic               valid_q;
	blag_result_t       res_q;

	// Add the stored pair to the current pair and weight the totals
	always_comb begin
		rt   = TOTAL_W'(s1.sums.r) + TOTAL_W'(line_rd.r);
		gt   = TOTAL_W'(s1.sums.g) + TOTAL_W'(line_rd.g);
		bt   = TOTAL_W'(s1.sums.b) + TOTAL_W'(line_rd.b);
		luma = LUMA_W'(rt) * LUMA_W'(WEIGHT_R)
		     + LUMA_W'(gt) * LUMA_W'(WEIGHT_G)
		     + LUMA_W'(bt) * LUMA_W'(WEIGHT_B);
	end

	// Stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rt_s2   <= rt;
			gt_s2   <= gt;
			bt_s2   <= bt;
			luma_s2 <= luma;
			bcol_s2 <= s1.bcol;
			done_s2 <= s1.done;
		end
	end

	// Output register: hold while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.glyph <= RAMP[luma_s2[LUMA_SHIFT +: RAMP_IDX_W]];
			res_q.r_avg <= rt_s2[TOTAL_W-1:2];
			res_q.g_avg <= gt_s2[TOTAL_W-1:2];
			res_q.b_avg <= bt_s2[TOTAL_W-1:2];
			res_q.bcol  <= bcol_s2;
			res_q.done  <= done_s2;
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;

endmodule

// ===== src/block_luma_ascii_glyph.sv =====
// Top level: 2x2 block color averager with ASCII luma-ramp glyph output.
// A result becomes valid after the transfer of the pixel that completes its 2x2 block,
// through three register stages (line buffer read, totals and luma, glyph).
// Throughput: one pixel per cycle unless the output is stalled; the line buffer takes one access per pixel pair.
// Reset clears column, row parity and pipeline valids and sets row_width to min(640, MAX_WIDTH);
// the line buffer is not cleared, it is always written on an even row before being read.
module block_luma_ascii_glyph #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: row_width
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data,
	// pixel stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  logic        s_tuser,   // frame_start
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // glyph[6:0], red_avg[14:7], green_avg[22:15],
	                               // blue_avg[30:23], block_column[41:31], zero[47:42]
	output logic        m_tlast    // row_done
);
	import blag_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EXT_W = (ROW_W_W > WW) ? ROW_W_W : WW;
	localparam int EFF_RESET = (ROW_W_RESET > MAX_WIDTH) ? MAX_WIDTH : ROW_W_RESET;

	logic [WW-1:0]    eff_w_q;
	logic [EXT_W-1:0] cfg_ext;
	logic [EXT_W-1:0] cfg_sat;
	logic             adv;
	logic             acc;
	blag_s1_t         s1;
	pair_sum_t        line_rd;
	logic             res_valid;
	blag_result_t     res;

	// Saturate the written width to the supported range
	always_comb begin
		cfg_ext = EXT_W'(cfg_data);
		if (cfg_ext < EXT_W'(2)) begin
			cfg_sat = EXT_W'(2);
		end else if (cfg_ext > EXT_W'(MAX_WIDTH)) begin
			cfg_sat = EXT_W'(MAX_WIDTH);
		end else begin
			cfg_sat = cfg_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= WW'(EFF_RESET);
		end else if (cfg_valid) begin
			eff_w_q <= cfg_sat[WW-1:0];
		end
	end

	assign cfg_ready = 1'b1;

	// Whole pipeline advances unless the output register is full and stalled
	assign adv      = !res_valid || m_tready;
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;

	blag_line #(
		.MAX_WIDTH (MAX_WIDTH),
		.WW        (WW)
	) u_line (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.acc         (acc),
		.red         (s_tdata[7:0]),
		.green       (s_tdata[15:8]),
		.blue        (s_tdata[23:16]),
		.frame_start (s_tuser),
		.eff_w       (eff_w_q),
		.s1          (s1),
		.line_rd     (line_rd)
	);

	blag_glyph u_glyph (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.s1        (s1),
		.line_rd   (line_rd),
		.res_valid (res_valid),
		.res       (res)
	);

	assign m_tvalid = res_valid;
	assign m_tdata  = {6'd0, res.bcol, res.b_avg, res.g_avg, res.r_avg, res.glyph};
	assign m_tlast  = res.done;

endmodule
